// ----- hdl/mbrtu_pkg.sv -----
// Shared types and constants for the Modbus RTU read-holding-registers slave.
package mbrtu_pkg;

    // Input item commands
    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_GAP    = 2'd2;

    // Accepted function codes
    localparam logic [7:0] FUNC_READ  = 8'h03;
    localparam logic [7:0] FUNC_ALT   = 8'h00;

    // CRC-16/MODBUS, reflected form
    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // Request frame layout: eight bytes, CRC covers the first six
    localparam logic [2:0] CRC_SPAN   = 3'd6;
    localparam logic [2:0] LAST_POS   = 3'd7;
    localparam logic [2:0] LAST_BIT   = 3'd7;

    // Longest response is 29 bytes, so at most 12 words
    localparam int          LEFT_W    = 4;
    localparam logic [15:0] MAX_WORDS = 16'd12;

    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;

    // Operations of the bit-serial CRC unit
    typedef enum logic [1:0] {
        CRC_HOLD  = 2'd0,
        CRC_INIT  = 2'd1,
        CRC_LOAD  = 2'd2,
        CRC_SHIFT = 2'd3
    } t_crc_op;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RXCRC  = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_TXBYTE = 7'b0001000,
        S_TXCRC  = 7'b0010000,
        S_CRCLO  = 7'b0100000,
        S_CRCHI  = 7'b1000000
    } t_state;

    // Which response byte goes out next
    typedef enum logic [2:0] {
        P_ADDR = 3'd0,
        P_FUNC = 3'd1,
        P_BCNT = 3'd2,
        P_HI   = 3'd3,
        P_LO   = 3'd4,
        P_CRC  = 3'd5
    } t_part;

endpackage

// ----- hdl/mbrtu_crc.sv -----
// Bit-serial CRC-16/MODBUS unit shared by request check and response build.
module mbrtu_crc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbrtu_pkg::t_crc_op i_op,
    input  logic [7:0]         i_byte,
    output logic [15:0]        o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // One byte = one load (xor) then eight shift steps
    always_comb begin
        case (i_op)
            mbrtu_pkg::CRC_HOLD:  n_crc = r_crc;
            mbrtu_pkg::CRC_INIT:  n_crc = mbrtu_pkg::CRC_SEED;
            mbrtu_pkg::CRC_LOAD:  n_crc = r_crc ^ {8'h00, i_byte};
            mbrtu_pkg::CRC_SHIFT: n_crc = r_crc[0] ? ((r_crc >> 1) ^ mbrtu_pkg::CRC_POLY)
                                                   : (r_crc >> 1);
            default:              n_crc = r_crc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mbrtu_pkg::CRC_SEED;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ----- hdl/mbrtu_regs.sv -----
// Holding register file: one write port, one read port.
module mbrtu_regs #(
    parameter int NUM_REGS = 12,
    parameter int AW       = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [3:0]    i_wr_idx,
    input  logic [15:0]   i_wr_data,
    input  logic [AW-1:0] i_rd_idx,
    output logic [15:0]   o_rd_data
);

    logic [15:0] r_regs [NUM_REGS];

    // Each entry matches its own index; out-of-range writes hit nothing
    for (genvar k = 0; k < NUM_REGS; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_regs[k] <= 16'h0000;
            end else if (i_we && (5'(i_wr_idx) == 5'(k))) begin
                r_regs[k] <= i_wr_data;
            end
        end
    end

    assign o_rd_data = r_regs[i_rd_idx];

endmodule

// ----- hdl/modbus_rtu_read_registers_slave_top.sv -----
// Top level of the Modbus RTU read-holding-registers slave.
//
// Items are accepted only while the sequencer is idle. A holding register
// write, a line gap or the seventh frame byte leaves it idle; each of the
// first six frame bytes runs through the shared bit-serial CRC unit as one
// load and eight shift steps. The eighth byte leads to a check state. While
// the output is taken, every emitted byte but the two CRC bytes passes
// through the same CRC unit one bit a cycle, so that unit sets the pace.
// Results leave through a single output register.
module modbus_rtu_read_registers_slave_top #(
    parameter int NUM_REGS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [3:0]  i_reg_index,
    input  logic [15:0] i_reg_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    mbrtu_pkg::t_state   r_state, n_state;
    mbrtu_pkg::t_part    r_part, n_part;
    mbrtu_pkg::t_crc_op  crc_op;
    logic [2:0]          r_pos, n_pos;
    logic [2:0]          r_bit, n_bit;
    logic [AW-1:0]       r_ridx, n_ridx;
    logic [mbrtu_pkg::LEFT_W-1:0] r_left, n_left;
    logic [7:0]          r_slave_addr;
    logic [7:0]          r_req [8];
    logic                r_out_valid;
    logic [7:0]          r_tx_byte;
    logic                r_last;

    logic        accept;
    logic        out_free;
    logic        out_load;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [7:0]  tx_sel;
    logic [7:0]  crc_byte;
    logic [15:0] crc_val;
    logic [15:0] rd_data;
    logic [15:0] req_start;
    logic [15:0] req_count;
    logic        frame_ok;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == mbrtu_pkg::S_IDLE);

    mbrtu_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (crc_op),
        .i_byte  (crc_byte),
        .o_crc   (crc_val)
    );

    mbrtu_regs #(
        .NUM_REGS (NUM_REGS),
        .AW       (AW)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (accept && (i_cmd == mbrtu_pkg::CMD_WRITE)),
        .i_wr_idx  (i_reg_index),
        .i_wr_data (i_reg_value),
        .i_rd_idx  (r_ridx),
        .o_rd_data (rd_data)
    );

    // Frame check on the completed request
    assign req_start = {r_req[2], r_req[3]};
    assign req_count = {r_req[4], r_req[5]};
    assign frame_ok  = (r_req[0] == r_slave_addr)
                    && ((r_req[1] == mbrtu_pkg::FUNC_READ) || (r_req[1] == mbrtu_pkg::FUNC_ALT))
                    && (crc_val == {r_req[7], r_req[6]})
                    && ((17'(req_start) + 17'(req_count)) <= 17'(NUM_REGS))
                    && (req_count <= mbrtu_pkg::MAX_WORDS);

    // Next response byte; byte count is 2*count, count already limited to 12
    always_comb begin
        case (r_part)
            mbrtu_pkg::P_ADDR: tx_sel = r_req[0];
            mbrtu_pkg::P_FUNC: tx_sel = r_req[1];
            mbrtu_pkg::P_BCNT: tx_sel = {r_req[5][6:0], 1'b0};
            mbrtu_pkg::P_HI:   tx_sel = rd_data[15:8];
            mbrtu_pkg::P_LO:   tx_sel = rd_data[7:0];
            default:           tx_sel = 8'h00;
        endcase
    end

    assign crc_byte = (r_state == mbrtu_pkg::S_IDLE) ? i_rx_byte : tx_sel;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_part   = r_part;
        n_pos    = r_pos;
        n_bit    = r_bit;
        n_ridx   = r_ridx;
        n_left   = r_left;
        crc_op   = mbrtu_pkg::CRC_HOLD;
        out_load = 1'b0;
        out_byte = tx_sel;
        out_last = 1'b0;
        case (r_state)
            mbrtu_pkg::S_IDLE: begin
                if (accept && (i_cmd == mbrtu_pkg::CMD_BYTE)) begin
                    n_pos = r_pos + 3'd1;
                    if (r_pos < mbrtu_pkg::CRC_SPAN) begin
                        crc_op  = mbrtu_pkg::CRC_LOAD;
                        n_bit   = 3'd0;
                        n_state = mbrtu_pkg::S_RXCRC;
                    end else if (r_pos == mbrtu_pkg::LAST_POS) begin
                        n_state = mbrtu_pkg::S_CHECK;
                    end
                end else if (accept && (i_cmd == mbrtu_pkg::CMD_GAP)) begin
                    n_pos  = 3'd0;
                    crc_op = mbrtu_pkg::CRC_INIT;
                end
            end
            mbrtu_pkg::S_RXCRC: begin
                crc_op = mbrtu_pkg::CRC_SHIFT;
                n_bit  = r_bit + 3'd1;
                if (r_bit == mbrtu_pkg::LAST_BIT) begin
                    n_state = mbrtu_pkg::S_IDLE;
                end
            end
            mbrtu_pkg::S_CHECK: begin
                // Seed is restored whether or not a response follows
                crc_op = mbrtu_pkg::CRC_INIT;
                n_pos  = 3'd0;
                if (frame_ok) begin
                    n_part  = mbrtu_pkg::P_ADDR;
                    n_ridx  = req_start[AW-1:0];
                    n_left  = req_count[mbrtu_pkg::LEFT_W-1:0];
                    n_state = mbrtu_pkg::S_TXBYTE;
                end else begin
                    n_state = mbrtu_pkg::S_IDLE;
                end
            end
            mbrtu_pkg::S_TXBYTE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    crc_op   = mbrtu_pkg::CRC_LOAD;
                    n_bit    = 3'd0;
                    n_state  = mbrtu_pkg::S_TXCRC;
                    case (r_part)
                        mbrtu_pkg::P_ADDR: n_part = mbrtu_pkg::P_FUNC;
                        mbrtu_pkg::P_FUNC: n_part = mbrtu_pkg::P_BCNT;
                        mbrtu_pkg::P_BCNT: n_part = (r_left == '0) ? mbrtu_pkg::P_CRC
                                                                   : mbrtu_pkg::P_HI;
                        mbrtu_pkg::P_HI:   n_part = mbrtu_pkg::P_LO;
                        mbrtu_pkg::P_LO: begin
                            n_ridx = r_ridx + AW'(1);
                            n_left = r_left - mbrtu_pkg::LEFT_W'(1);
                            n_part = (r_left == mbrtu_pkg::LEFT_W'(1)) ? mbrtu_pkg::P_CRC
                                                                        : mbrtu_pkg::P_HI;
                        end
                        default:           n_part = mbrtu_pkg::P_CRC;
                    endcase
                end
            end
            mbrtu_pkg::S_TXCRC: begin
                crc_op = mbrtu_pkg::CRC_SHIFT;
                n_bit  = r_bit + 3'd1;
                if (r_bit == mbrtu_pkg::LAST_BIT) begin
                    n_state = (r_part == mbrtu_pkg::P_CRC) ? mbrtu_pkg::S_CRCLO
                                                           : mbrtu_pkg::S_TXBYTE;
                end
            end
            mbrtu_pkg::S_CRCLO: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_byte = crc_val[7:0];
                    n_state  = mbrtu_pkg::S_CRCHI;
                end
            end
            mbrtu_pkg::S_CRCHI: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_byte = crc_val[15:8];
                    out_last = 1'b1;
                    crc_op   = mbrtu_pkg::CRC_INIT;
                    n_state  = mbrtu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbrtu_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mbrtu_pkg::S_IDLE;
            r_part       <= mbrtu_pkg::P_ADDR;
            r_pos        <= 3'd0;
            r_bit        <= 3'd0;
            r_left       <= '0;
            r_ridx       <= '0;
            r_slave_addr <= mbrtu_pkg::SLAVE_ADDR_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_pos   <= n_pos;
            r_bit   <= n_bit;
            r_left  <= n_left;
            r_ridx  <= n_ridx;
            if (i_cfg_we) begin
                r_slave_addr <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request bytes and output payload
    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd == mbrtu_pkg::CMD_BYTE)) begin
            r_req[r_pos] <= i_rx_byte;
        end
        if (out_load) begin
            r_tx_byte <= out_byte;
            r_last    <= out_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_tx_byte = r_tx_byte;
    assign o_last    = r_last;

endmodule
